// ===== hdl/ran_pkg.sv =====
// ----------------------------------------------------------------------------
// ran_pkg
// Shared types and constants for the rational add and reduce block.
// ----------------------------------------------------------------------------
`default_nettype none

package ran_pkg;

  // Width of the input fields and of the reduced sum.
  localparam int NARROW = 32;
  localparam int WIDE   = 64;

  // Trial divisors run from 2 up to this value.
  localparam int MAX_TRIAL_DIVISOR = 31;
  localparam int TRIAL_W = $clog2(MAX_TRIAL_DIVISOR + 1);

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = WIDE / DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_BO,
    S_MUL_OB,
    S_MUL_BD,
    S_COMB,
    S_CHECK,
    S_LAUNCH,
    S_DIV_NUM,
    S_DIV_DEN,
    S_OUT
  } state_e;

  // Request from the sequencer to the trial divider.
  typedef struct packed {
    logic               start;
    logic [TRIAL_W-1:0] divisor;
  } div_req_t;

  // Status returned by the trial divider.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_status_t;

endpackage

`default_nettype wire

// ===== hdl/ran_trial_div.sv =====
// ----------------------------------------------------------------------------
// ran_trial_div
// Unsigned 64-bit by 5-bit divider, several quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ran_trial_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ran_pkg::div_req_t        req_i,
  input  wire logic [ran_pkg::WIDE-1:0] dividend_i,
  output ran_pkg::div_status_t          status_o,
  output logic [ran_pkg::WIDE-1:0]      quotient_o
);
  import ran_pkg::*;

  logic [WIDE-1:0]      quo_q, quo_d;
  logic [TRIAL_W-1:0]   rem_q, rem_d;
  logic [TRIAL_W-1:0]   div_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  // Restoring division over the next group of dividend bits.
  always_comb begin
    logic [TRIAL_W:0] trial;
    trial = '0;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, quo_d[WIDE-1]};
      quo_d = {quo_d[WIDE-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d    = TRIAL_W'(trial - {1'b0, div_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[TRIAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o        = quo_q;
  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ===== hdl/rational_add_normalize.sv =====
// ----------------------------------------------------------------------------
// rational_add_normalize
// Adds two sign-in-denominator fractions and reduces the sum by trial division.
// ----------------------------------------------------------------------------
// Usage: drive the four 32-bit fields and raise start_i. The item is taken at
// a rising edge where start_i is high and busy_o is low; busy_o then stays
// high until the result is shown. The result appears on sum_numerator_o and
// sum_denominator_o, marked by done_o, high for a single cycle. The receiver
// cannot stall; it must take the item in that cycle. A new item may be
// started in the cycle done_o is high.
// A zero offset numerator returns the base directly. Otherwise one shared
// 32x32 multiplier forms the three products in turn, then the sum is built
// and checked. Reduction uses one shared divider that retires 8 quotient
// bits per cycle: each divisor is tried on the numerator, and on the
// denominator too when the numerator divides. A pass tries divisors 2 to
// 31, and every common factor found restarts the pass at 2. The divider is
// the limiting unit.
// Reset clears the sequencer and the strobe; no item is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_normalize (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic signed [ran_pkg::NARROW-1:0] base_numerator_i,
  input  wire logic signed [ran_pkg::NARROW-1:0] base_denominator_i,
  input  wire logic signed [ran_pkg::NARROW-1:0] offset_numerator_i,
  input  wire logic signed [ran_pkg::NARROW-1:0] offset_denominator_i,
  output logic                                   done_o,
  output logic signed [ran_pkg::WIDE-1:0]        sum_numerator_o,
  output logic signed [ran_pkg::WIDE-1:0]        sum_denominator_o
);
  import ran_pkg::*;

  state_e state_q, state_d;

  // Captured operands.
  logic signed [NARROW-1:0] bn_q, bd_q, on_q, od_q;

  // Products from the shared multiplier.
  logic signed [WIDE-1:0] p_bo_q, p_bo_d;
  logic signed [WIDE-1:0] p_ob_q, p_ob_d;
  logic signed [WIDE-1:0] p_bd_q, p_bd_d;

  // Working fraction and the current trial divisor.
  logic signed [WIDE-1:0] num_q, num_d;
  logic signed [WIDE-1:0] den_q, den_d;
  logic [WIDE-1:0]        qn_q, qn_d;
  logic [TRIAL_W-1:0]     trial_q, trial_d;

  // Result registers.
  logic                   done_q, done_d;
  logic signed [WIDE-1:0] sum_num_q, sum_num_d;
  logic signed [WIDE-1:0] sum_den_q, sum_den_d;

  // Shared multiplier.
  logic signed [NARROW-1:0] mul_a, mul_b;
  logic signed [WIDE-1:0]   mul_p;

  // Divider interface.
  div_req_t        div_req;
  div_status_t     div_status;
  logic [WIDE-1:0] div_dividend;
  logic [WIDE-1:0] div_quotient;

  // Combined sum before reduction.
  logic signed [WIDE-1:0] bn_x, bd_x, on_x, od_x;
  logic signed [WIDE-1:0] cross_sum;
  logic signed [WIDE-1:0] comb_num, comb_den;
  logic [WIDE-1:0]        num_mag, den_mag;

  logic accept;

  assign accept = start_i && (state_q == S_IDLE);

  assign mul_p = WIDE'(mul_a) * WIDE'(mul_b);

  assign bn_x = WIDE'(bn_q);
  assign bd_x = WIDE'(bd_q);
  assign on_x = WIDE'(on_q);
  assign od_x = WIDE'(od_q);

  assign cross_sum = p_bo_q + p_ob_q;

  // Magnitudes for the divider; the most negative value maps to 2^63.
  assign num_mag = num_q[WIDE-1] ? WIDE'(-num_q) : WIDE'(num_q);
  assign den_mag = den_q[WIDE-1] ? WIDE'(-den_q) : WIDE'(den_q);

  // Sign cases. Equal denominator magnitudes combine the numerators; any
  // other pair cross-multiplies, negated when the base is negative.
  always_comb begin
    logic bneg, oneg;
    bneg = bd_q[NARROW-1];
    oneg = od_q[NARROW-1];
    comb_num = bneg ? -cross_sum : cross_sum;
    comb_den = bneg ? -p_bd_q : p_bd_q;
    if (bneg == oneg) begin
      if (od_x == bd_x) begin
        comb_num = bn_x + on_x;
        comb_den = bd_x;
      end
    end else if (bneg) begin
      if (od_x == -bd_x) begin
        comb_num = bn_x - on_x;
        comb_den = bd_x;
      end
    end else begin
      if (od_x == -bd_x) begin
        comb_num = on_x - bn_x;
        comb_den = -bd_x;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    p_bo_d    = p_bo_q;
    p_ob_d    = p_ob_q;
    p_bd_d    = p_bd_q;
    num_d     = num_q;
    den_d     = den_q;
    qn_d      = qn_q;
    trial_d   = trial_q;
    done_d    = 1'b0;
    sum_num_d = sum_num_q;
    sum_den_d = sum_den_q;
    mul_a     = bn_q;
    mul_b     = od_q;
    div_req.start   = 1'b0;
    div_req.divisor = trial_q;
    div_dividend    = num_mag;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // A zero offset returns the base as it stands, unreduced.
          if (offset_numerator_i == '0) begin
            num_d   = WIDE'(base_numerator_i);
            den_d   = WIDE'(base_denominator_i);
            state_d = S_OUT;
          end else begin
            state_d = S_MUL_BO;
          end
        end
      end
      S_MUL_BO: begin
        mul_a   = bn_q;
        mul_b   = od_q;
        p_bo_d  = mul_p;
        state_d = S_MUL_OB;
      end
      S_MUL_OB: begin
        mul_a   = on_q;
        mul_b   = bd_q;
        p_ob_d  = mul_p;
        state_d = S_MUL_BD;
      end
      S_MUL_BD: begin
        mul_a   = bd_q;
        mul_b   = od_q;
        p_bd_d  = mul_p;
        state_d = S_COMB;
      end
      S_COMB: begin
        num_d   = comb_num;
        den_d   = comb_den;
        trial_d = TRIAL_W'(2);
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // A zero over zero sum skips the reduction.
        if (num_q == '0 && den_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        div_req.start = 1'b1;
        div_dividend  = num_mag;
        state_d       = S_DIV_NUM;
      end
      S_DIV_NUM: begin
        if (div_status.done) begin
          if (div_status.rem_zero) begin
            // The numerator divides; test the denominator next.
            qn_d          = div_quotient;
            div_req.start = 1'b1;
            div_dividend  = den_mag;
            state_d       = S_DIV_DEN;
          end else if (trial_q == TRIAL_W'(MAX_TRIAL_DIVISOR)) begin
            state_d = S_OUT;
          end else begin
            trial_d = trial_q + 1'b1;
            state_d = S_LAUNCH;
          end
        end
      end
      S_DIV_DEN: begin
        if (div_status.done) begin
          if (div_status.rem_zero) begin
            // Common factor: divide both and restart the trial at two.
            num_d   = num_q[WIDE-1] ? -$signed(qn_q) : $signed(qn_q);
            den_d   = den_q[WIDE-1] ? -$signed(div_quotient) : $signed(div_quotient);
            trial_d = TRIAL_W'(2);
            state_d = S_LAUNCH;
          end else if (trial_q == TRIAL_W'(MAX_TRIAL_DIVISOR)) begin
            state_d = S_OUT;
          end else begin
            trial_d = trial_q + 1'b1;
            state_d = S_LAUNCH;
          end
        end
      end
      S_OUT: begin
        done_d    = 1'b1;
        sum_num_d = num_q;
        sum_den_d = den_q;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bn_q <= base_numerator_i;
      bd_q <= base_denominator_i;
      on_q <= offset_numerator_i;
      od_q <= offset_denominator_i;
    end
    p_bo_q    <= p_bo_d;
    p_ob_q    <= p_ob_d;
    p_bd_q    <= p_bd_d;
    num_q     <= num_d;
    den_q     <= den_d;
    qn_q      <= qn_d;
    trial_q   <= trial_d;
    sum_num_q <= sum_num_d;
    sum_den_q <= sum_den_d;
  end

  ran_trial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .status_o   (div_status),
    .quotient_o (div_quotient)
  );

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign sum_numerator_o   = sum_num_q;
  assign sum_denominator_o = sum_den_q;

endmodule

`default_nettype wire

// ===== test/rational_add_normalize_tb.sv =====
// ----------------------------------------------------------------------------
// rational_add_normalize_tb
// Self-checking bench for the fraction adder with trial-division reduction.
// A directed set covers every denominator sign case, the equal-magnitude
// paths, the zero offset bypass, the 0/0 case and the field extremes. It is
// followed by random operands, many of them built from small primes so that
// the reducer finds long chains of common factors. Every reduced sum is
// checked against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_normalize_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [ran_pkg::NARROW-1:0] field_t;
  typedef logic signed [ran_pkg::WIDE-1:0]   wide_t;

  // One pair of addends. When wait_drain is set, the driver holds the item
  // back until every outstanding sum has come out of the block.
  typedef struct {
    field_t base_num;
    field_t base_den;
    field_t offset_num;
    field_t offset_den;
    bit     wait_drain;
  } operands_t;

  typedef struct {
    wide_t num;
    wide_t den;
  } fraction_t;

  localparam field_t FIELD_MAX   = 32'sh7fff_ffff;
  localparam field_t FIELD_MIN   = 32'sh8000_0000;
  localparam longint FIELD_LIMIT = 64'sd2147483647;

  localparam int RANDOM_ITEMS = 1150;
  // Random gaps are long enough that the block is sometimes left idle and a
  // new item lands at any point of its work.
  localparam int GAP_PERCENT  = 20;
  localparam int MAX_GAP      = 1200;
  // No gaps at all while this range of items is being sent.
  localparam int QUIET_FROM   = 400;
  localparam int QUIET_TO     = 650;
  // Each common factor costs at most one pass over the divisors, and a 64-bit
  // magnitude holds at most 63 prime factors, no more than 12 of them 31, so a
  // reduction is bounded; the stall limit leaves a wide margin over that plus
  // a gap.
  localparam int STALL_LIMIT  = 100000;
  localparam int TAIL_CYCLES  = 1200;
  localparam int REPORT_LIMIT = 100;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  field_t base_numerator_i = '0;
  field_t base_denominator_i = '0;
  field_t offset_numerator_i = '0;
  field_t offset_denominator_i = '0;
  logic   busy_o;
  logic   done_o;
  wide_t  sum_numerator_o;
  wide_t  sum_denominator_o;

  operands_t queued_operands[$];
  fraction_t expected_sums[$];
  int        items_raised = 0;
  int        items_taken = 0;
  int        gap_left = 0;
  int        stall_cycles = 0;
  int        errors = 0;
  int        small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

  rational_add_normalize u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start_i              (start_i),
    .busy_o               (busy_o),
    .base_numerator_i     (base_numerator_i),
    .base_denominator_i   (base_denominator_i),
    .offset_numerator_i   (offset_numerator_i),
    .offset_denominator_i (offset_denominator_i),
    .done_o               (done_o),
    .sum_numerator_o      (sum_numerator_o),
    .sum_denominator_o    (sum_denominator_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Expected sum. All arithmetic is 64-bit two's complement, so the products
  // and the cross sum wrap exactly as the block's datapath does. The sign of
  // each addend lives in its denominator, which selects one of four cases.
  // --------------------------------------------------------------------------
  function automatic fraction_t add_and_reduce(input field_t bn32, input field_t bd32,
                                               input field_t on32, input field_t od32);
    wide_t     bn;
    wide_t     bd;
    wide_t     on;
    wide_t     od;
    wide_t     cross_sum;
    wide_t     num;
    wide_t     den;
    wide_t     divisor;
    fraction_t sum;
    bn = bn32;
    bd = bd32;
    on = on32;
    od = od32;
    // A zero offset passes the base through, sign-extended and unreduced.
    if (on == 0) begin
      sum.num = bn;
      sum.den = bd;
      return sum;
    end
    cross_sum = bn * od + on * bd;
    if (bd < 0) begin
      if (od < 0) begin
        if (od == bd) begin
          num = bn + on;
          den = bd;
        end else begin
          num = -cross_sum;
          den = -(bd * od);
        end
      end else if (od == -bd) begin
        num = bn - on;
        den = bd;
      end else begin
        num = -cross_sum;
        den = bd * (-od);
      end
    end else begin
      if (od < 0) begin
        if (od == -bd) begin
          num = on - bn;
          den = -bd;
        end else begin
          num = cross_sum;
          den = bd * od;
        end
      end else if (od == bd) begin
        num = bn + on;
        den = bd;
      end else begin
        num = cross_sum;
        den = bd * od;
      end
    end
    // Trial division restarts at 2 after every common factor. A 0/0 sum is
    // left alone; a zero denominator alone still strips small factors from
    // the numerator, since zero is divisible by everything.
    if (!(num == 0 && den == 0)) begin
      divisor = 2;
      while (divisor <= ran_pkg::MAX_TRIAL_DIVISOR) begin
        if (num % divisor == 0 && den % divisor == 0) begin
          num = num / divisor;
          den = den / divisor;
          divisor = 2;
        end else begin
          divisor = divisor + 1;
        end
      end
    end
    sum.num = num;
    sum.den = den;
    return sum;
  endfunction

  // Positive product of random small primes, at most limit.
  function automatic longint rich_value(input longint limit);
    longint v;
    longint p;
    v = 1;
    repeat ($urandom_range(1, 31)) begin
      p = small_primes[$urandom_range(10)];
      if (v * p <= limit) v = v * p;
    end
    return v;
  endfunction

  function automatic field_t flip(input field_t v);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random signed multiple of factor, so that several fields share it.
  function automatic field_t with_factor(input longint factor);
    longint v;
    v = factor * rich_value(FIELD_LIMIT / factor);
    return flip(v[31:0]);
  endfunction

  function automatic void queue_operands(input field_t bn, input field_t bd,
                                         input field_t on, input field_t od,
                                         input bit drain);
    operands_t item;
    item.base_num   = bn;
    item.base_den   = bd;
    item.offset_num = on;
    item.offset_den = od;
    item.wait_drain = drain;
    queued_operands.push_back(item);
  endfunction

  // --------------------------------------------------------------------------
  // Driver. Inputs change on the falling edge. An item is held on the port
  // until the block takes it; the monitor counts each take in items_taken, so
  // the port is free again once that count catches up with items_raised.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    operands_t next_item;
    if (rst_ni && (!start_i || items_taken == items_raised)) begin
      // The item on the port was just taken: maybe leave the port idle a while.
      if (start_i) begin
        if (items_raised >= QUIET_FROM && items_raised < QUIET_TO)
          gap_left = 0;
        else if ($urandom_range(99) < GAP_PERCENT)
          gap_left = $urandom_range(1, MAX_GAP);
        else
          gap_left = 0;
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start_i <= 1'b0;
      end else if (queued_operands.size() != 0 &&
                   !(queued_operands[0].wait_drain && expected_sums.size() != 0)) begin
        next_item = queued_operands.pop_front();
        base_numerator_i     <= next_item.base_num;
        base_denominator_i   <= next_item.base_den;
        offset_numerator_i   <= next_item.offset_num;
        offset_denominator_i <= next_item.offset_den;
        start_i              <= 1'b1;
        items_raised = items_raised + 1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. On each rising edge a strobed sum is checked against the oldest
  // expectation, then a newly taken item adds its own. Both can happen at the
  // same edge, since a new item may start while the previous sum is shown.
  // The watchdog ends the run when neither side moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_sums.size() == 0) begin
          errors = errors + 1;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected sum, expected none, got %0d / %0d",
                     $time, sum_numerator_o, sum_denominator_o);
        end else begin
          want = expected_sums.pop_front();
          if (sum_numerator_o !== want.num) begin
            errors = errors + 1;
            if (errors <= REPORT_LIMIT)
              $display("%0t: sum_numerator mismatch, expected %0d, got %0d",
                       $time, want.num, sum_numerator_o);
          end
          if (sum_denominator_o !== want.den) begin
            errors = errors + 1;
            if (errors <= REPORT_LIMIT)
              $display("%0t: sum_denominator mismatch, expected %0d, got %0d",
                       $time, want.den, sum_denominator_o);
          end
        end
      end
      if (start_i && busy_o === 1'b0) begin
        expected_sums.push_back(add_and_reduce(base_numerator_i, base_denominator_i,
                                               offset_numerator_i, offset_denominator_i));
        items_taken = items_taken + 1;
      end
      if (done_o === 1'b1 || (start_i && busy_o === 1'b0))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL rational_add_normalize");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int     pick;
    longint shared;
    field_t a;
    field_t b;
    field_t c;
    field_t d;

    // Zero offset numerator: the base comes back as it is, extremes included.
    queue_operands(FIELD_MAX, FIELD_MAX, 0, 5, 1'b0);
    queue_operands(FIELD_MIN, FIELD_MIN, 0, -7, 1'b0);
    queue_operands(0, 0, 0, 0, 1'b0);
    // A sum of 0/0 skips reduction; a lone zero denominator does not.
    queue_operands(5, 0, -5, 0, 1'b0);
    queue_operands(12, 0, 18, 0, 1'b0);
    queue_operands(6, 0, 4, 9, 1'b0);
    // The four sign cases, each with its equal-magnitude shortcut and without.
    queue_operands(3, -12, 5, -12, 1'b0);
    queue_operands(7, -6, -5, -10, 1'b0);
    queue_operands(9, -15, 4, 15, 1'b0);
    queue_operands(1, -3, 1, 4, 1'b0);
    queue_operands(2, 8, 6, -8, 1'b0);
    queue_operands(5, 9, 7, -21, 1'b0);
    queue_operands(1, 4, 1, 4, 1'b0);
    queue_operands(1, 6, 1, 10, 1'b0);
    // Field extremes, where the products come close to the 64-bit limit.
    queue_operands(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX, 1'b0);
    queue_operands(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN, 1'b0);
    queue_operands(FIELD_MAX, -FIELD_MAX, FIELD_MIN, FIELD_MAX - 1, 1'b0);
    queue_operands(FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN, 1'b0);
    queue_operands(FIELD_MIN, -1, FIELD_MIN, FIELD_MIN, 1'b0);
    queue_operands(1, FIELD_MAX, -1, FIELD_MIN, 1'b0);
    // Powers of two and three, and long reduction chains of eleven factors of 31.
    queue_operands(536870912, 1073741824, 1162261467, 1073741824, 1'b0);
    queue_operands(887503681, 887503681, 887503681, 28629151, 1'b0);
    queue_operands(-887503681, -28629151, 887503681, 887503681, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // Full-range noise; every bit of every field toggles here.
        a = $urandom;
        b = $urandom;
        c = $urandom;
        d = $urandom;
      end else if (pick < 55) begin
        // All four share a factor, so the sum reduces over several rounds.
        shared = rich_value(4096);
        a = with_factor(shared);
        b = with_factor(shared);
        c = with_factor(shared);
        d = with_factor(shared);
      end else if (pick < 65) begin
        a = flip(rich_value(FIELD_LIMIT));
        b = flip(rich_value(FIELD_LIMIT));
        c = flip(rich_value(FIELD_LIMIT));
        d = flip(rich_value(FIELD_LIMIT));
      end else if (pick < 75) begin
        // Denominators of equal magnitude, same or opposite sign.
        a = $urandom_range(1) ? field_t'($urandom) : flip(rich_value(FIELD_LIMIT));
        b = $urandom_range(1) ? field_t'($urandom) : flip(rich_value(FIELD_LIMIT));
        c = $urandom_range(1) ? field_t'($urandom) : flip(rich_value(FIELD_LIMIT));
        d = $urandom_range(1) ? b : -b;
      end else if (pick < 82) begin
        a = $urandom;
        b = $urandom;
        c = 0;
        d = $urandom;
      end else if (pick < 88) begin
        a = flip(rich_value(FIELD_LIMIT));
        c = flip(rich_value(FIELD_LIMIT));
        b = 0;
        d = 0;
        case ($urandom_range(3))
          0: c = -a;
          1: ;
          2: d = flip(rich_value(FIELD_LIMIT));
          default: b = flip(rich_value(FIELD_LIMIT));
        endcase
      end else begin
        a = $urandom_range(128) - 64;
        b = $urandom_range(128) - 64;
        c = $urandom_range(128) - 64;
        d = $urandom_range(128) - 64;
      end
      // Now and then the sender waits for the block to drain completely.
      queue_operands(a, b, c, d, (i % 300) == 150);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_operands.size() != 0 || items_taken != items_raised ||
           expected_sums.size() != 0)
      @(negedge clk_i);
    // Any stray sum after the last one would show up as unexpected here.
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (errors == 0)
      $display("PASS rational_add_normalize");
    else
      $display("FAIL rational_add_normalize");
    $finish;
  end

endmodule

`default_nettype wire

// ===== rational_add_normalize.f =====
hdl/ran_pkg.sv
hdl/ran_trial_div.sv
hdl/rational_add_normalize.sv
test/rational_add_normalize_tb.sv
